### hw/rtl/tog_pkg.sv
// shared types and constants of the text overlay glyph shadow renderer
package tog_pkg;

  localparam int COLUMNS_DEF  = 80;
  localparam int ROWS_DEF     = 30;
  localparam int GLYPH_WIDTH  = 8;
  localparam int GLYPH_HEIGHT = 16;
  localparam int GLYPH_DEPTH  = 256 * GLYPH_HEIGHT;
  localparam int GLYPH_AW     = $clog2(GLYPH_DEPTH);

  localparam int RGB_W  = 24;
  localparam int IDX_W  = 12;
  localparam int CELL_W = 10;
  localparam int COL_W  = 7;
  localparam int ROW_W  = 5;
  localparam int GX_W   = $clog2(GLYPH_WIDTH);
  localparam int GY_W   = $clog2(GLYPH_HEIGHT);

  localparam logic [1:0] ACT_RENDER = 2'd0;
  localparam logic [1:0] ACT_CELL   = 2'd1;
  localparam logic [1:0] ACT_GLYPH  = 2'd2;

  localparam logic [1:0] CFG_FOREGROUND = 2'd0;
  localparam logic [1:0] CFG_SHADOW     = 2'd1;
  localparam logic [1:0] CFG_HAS_BG     = 2'd2;
  localparam logic [1:0] CFG_COLUMNS    = 2'd3;

  localparam logic [RGB_W-1:0] FOREGROUND_RST = 24'hff_ffff;
  localparam logic [RGB_W-1:0] SHADOW_RST     = 24'h00_0000;
  localparam logic [COL_W-1:0] COLUMNS_RST    = 7'd80;

  typedef struct packed {
    logic              valid;
    logic [1:0]        action;
    logic              cell_we;
    logic [IDX_W-1:0]  cell_index;
    logic [CELL_W-1:0] cell_word;
    logic [IDX_W-1:0]  font_address;
    logic [7:0]        font_row_bits;
    logic [RGB_W-1:0]  background_rgb;
    logic [IDX_W-1:0]  main_idx;
    logic              main_ok;
    logic [IDX_W-1:0]  nb_idx;
    logic              nb_ok;
    logic [GX_W-1:0]   gx;
    logic [GY_W-1:0]   gy;
    logic [GX_W-1:0]   sgx;
    logic [GY_W-1:0]   sgy;
  } pix_t;

  typedef struct packed {
    logic              main_ok;
    logic              nb_ok;
    logic              swap;
    logic [GX_W-1:0]   gx;
    logic [GX_W-1:0]   sgx;
    logic [RGB_W-1:0]  background_rgb;
  } shade_t;

endpackage

### hw/rtl/tog_ram.sv
// generic single write port ram with registered read
module tog_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### hw/rtl/tog_index.sv
// pixel split, shadow neighbour and cell index stages
module tog_index #(
  parameter int CELL_DEPTH = tog_pkg::COLUMNS_DEF * tog_pkg::ROWS_DEF
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       adv_i,
  input  logic                       valid_i,
  input  logic [1:0]                 action_i,
  input  logic [11:0]                cell_index_i,
  input  logic [7:0]                 char_code_i,
  input  logic                       invert_flag_i,
  input  logic                       cursor_flag_i,
  input  logic [11:0]                font_address_i,
  input  logic [7:0]                 font_row_bits_i,
  input  logic [9:0]                 pixel_x_i,
  input  logic [8:0]                 pixel_y_i,
  input  logic [23:0]                background_rgb_i,
  input  logic [tog_pkg::COL_W-1:0]  text_columns_i,
  output tog_pkg::pix_t              pix_o
);

  typedef struct packed {
    logic                          valid;
    logic [1:0]                    action;
    logic                          cell_we;
    logic [tog_pkg::IDX_W-1:0]     cell_index;
    logic [tog_pkg::CELL_W-1:0]    cell_word;
    logic [tog_pkg::IDX_W-1:0]     font_address;
    logic [7:0]                    font_row_bits;
    logic [tog_pkg::RGB_W-1:0]     background_rgb;
    logic [tog_pkg::COL_W-1:0]     col;
    logic [tog_pkg::ROW_W-1:0]     row;
    logic [tog_pkg::COL_W-1:0]     scol;
    logic [tog_pkg::ROW_W-1:0]     srow;
    logic                          edge_ok;
    logic [tog_pkg::GX_W-1:0]      gx;
    logic [tog_pkg::GY_W-1:0]      gy;
    logic [tog_pkg::GX_W-1:0]      sgx;
    logic [tog_pkg::GY_W-1:0]      sgy;
  } split_t;

  split_t        s1_d, s1_q;
  tog_pkg::pix_t s2_d, s2_q;

  logic [tog_pkg::COL_W-1:0] col;
  logic [tog_pkg::ROW_W-1:0] row;
  logic [tog_pkg::GX_W-1:0]  gx;
  logic [tog_pkg::GY_W-1:0]  gy;
  logic [tog_pkg::IDX_W-1:0] main_idx, nb_idx;

  assign col = pixel_x_i[9:tog_pkg::GX_W];
  assign gx  = pixel_x_i[tog_pkg::GX_W-1:0];
  assign row = pixel_y_i[8:tog_pkg::GY_W];
  assign gy  = pixel_y_i[tog_pkg::GY_W-1:0];

  always_comb begin
    s1_d = '0;
    s1_d.valid          = valid_i;
    s1_d.action         = action_i;
    s1_d.cell_we        = (action_i == tog_pkg::ACT_CELL) &&
                          (32'(cell_index_i) < 32'(CELL_DEPTH));
    s1_d.cell_index     = cell_index_i;
    s1_d.cell_word      = {cursor_flag_i, invert_flag_i, char_code_i};
    s1_d.font_address   = font_address_i;
    s1_d.font_row_bits  = font_row_bits_i;
    s1_d.background_rgb = background_rgb_i;
    s1_d.col            = col;
    s1_d.row            = row;
    s1_d.gx             = gx;
    s1_d.gy             = gy;
    s1_d.edge_ok        = 1'b1;
    // shadow source is one up and one left, possibly in the neighbour cell
    if (gx == '0) begin
      s1_d.scol = col - 1'b1;
      s1_d.sgx  = '1;
      if (col == '0) begin
        s1_d.edge_ok = 1'b0;
      end
    end else begin
      s1_d.scol = col;
      s1_d.sgx  = gx - 1'b1;
    end
    if (gy == '0) begin
      s1_d.srow = row - 1'b1;
      s1_d.sgy  = '1;
      if (row == '0) begin
        s1_d.edge_ok = 1'b0;
      end
    end else begin
      s1_d.srow = row;
      s1_d.sgy  = gy - 1'b1;
    end
  end

  assign main_idx = tog_pkg::IDX_W'(s1_q.row) * tog_pkg::IDX_W'(text_columns_i)
                  + tog_pkg::IDX_W'(s1_q.col);
  assign nb_idx   = tog_pkg::IDX_W'(s1_q.srow) * tog_pkg::IDX_W'(text_columns_i)
                  + tog_pkg::IDX_W'(s1_q.scol);

  always_comb begin
    s2_d.valid          = s1_q.valid;
    s2_d.action         = s1_q.action;
    s2_d.cell_we        = s1_q.cell_we;
    s2_d.cell_index     = s1_q.cell_index;
    s2_d.cell_word      = s1_q.cell_word;
    s2_d.font_address   = s1_q.font_address;
    s2_d.font_row_bits  = s1_q.font_row_bits;
    s2_d.background_rgb = s1_q.background_rgb;
    s2_d.main_idx       = main_idx;
    s2_d.main_ok        = 32'(main_idx) < 32'(CELL_DEPTH);
    s2_d.nb_idx         = nb_idx;
    s2_d.nb_ok          = s1_q.edge_ok && (32'(nb_idx) < 32'(CELL_DEPTH));
    s2_d.gx             = s1_q.gx;
    s2_d.gy             = s1_q.gy;
    s2_d.sgx            = s1_q.sgx;
    s2_d.sgy            = s1_q.sgy;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_q <= '0;
      s2_q <= '0;
    end else if (adv_i) begin
      s1_q <= s1_d;
      s2_q <= s2_d;
    end
  end

  assign pix_o = s2_q;

endmodule

### hw/rtl/tog_compose.sv
// colour selection from glyph bits, shadow bit and cell flags
module tog_compose (
  input  tog_pkg::shade_t            shade_i,
  input  logic [7:0]                 glyph_main_i,
  input  logic [7:0]                 glyph_nb_i,
  input  logic [tog_pkg::RGB_W-1:0]  foreground_i,
  input  logic [tog_pkg::RGB_W-1:0]  shadow_i,
  input  logic                       has_background_i,
  output logic [tog_pkg::RGB_W-1:0]  pixel_rgb_o,
  output logic                       overlay_drawn_o
);

  logic lit, shade;

  // msb is the leftmost pixel
  assign lit   = shade_i.main_ok && glyph_main_i[~shade_i.gx];
  assign shade = shade_i.nb_ok && glyph_nb_i[~shade_i.sgx];

  always_comb begin
    overlay_drawn_o = 1'b1;
    priority if (shade_i.swap) begin
      pixel_rgb_o = lit ? shadow_i : foreground_i;
    end else if (lit) begin
      pixel_rgb_o = foreground_i;
    end else if (!has_background_i || shade) begin
      pixel_rgb_o = shadow_i;
    end else begin
      pixel_rgb_o     = shade_i.background_rgb;
      overlay_drawn_o = 1'b0;
    end
  end

endmodule

### hw/rtl/text_overlay_glyph_shadow_render.sv
// Text overlay renderer with drop shadow: cell and glyph stores plus pixel pipeline.
// One item is taken every clock cycle while in_stall_o is low; a render item passes
// through five register stages (split, cell index multiply, cell read, glyph read,
// compose into the output register), and write items flow through the same stages
// and give no result. The rate is set by the registered reads of the duplicated cell
// and glyph stores, which are read at the pixel's own cell and at its shadow neighbour
// in the same cycle. A skid stage behind the output register lets one more item enter
// while a result waits; in_stall_o rises only when that stage is full. Neither store
// is cleared after reset, so the block is ready at once; cells and glyph rows must be
// written before they are shown.
module text_overlay_glyph_shadow_render #(
  parameter int COLUMNS = tog_pkg::COLUMNS_DEF,
  parameter int ROWS    = tog_pkg::ROWS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  action_i,
  input  logic [11:0] cell_index_i,
  input  logic [7:0]  char_code_i,
  input  logic        invert_flag_i,
  input  logic        cursor_flag_i,
  input  logic [11:0] font_address_i,
  input  logic [7:0]  font_row_bits_i,
  input  logic [9:0]  pixel_x_i,
  input  logic [8:0]  pixel_y_i,
  input  logic [23:0] background_rgb_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [23:0] pixel_rgb_o,
  output logic        overlay_drawn_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [23:0] cfg_data_i
);

  localparam int CELL_DEPTH = COLUMNS * ROWS;
  localparam int CELL_AW    = (CELL_DEPTH > 1) ? $clog2(CELL_DEPTH) : 1;
  localparam int IXW        = (CELL_AW > tog_pkg::IDX_W) ? CELL_AW : tog_pkg::IDX_W;

  logic [tog_pkg::RGB_W-1:0] foreground_q, shadow_q;
  logic                      has_background_q;
  logic [tog_pkg::COL_W-1:0] text_columns_q;

  logic adv;

  tog_pkg::pix_t   s2, s3_q;
  tog_pkg::shade_t s4_d, s4_q;
  logic            s4_valid_q;

  logic [tog_pkg::CELL_W-1:0] cell_main, cell_nb;
  logic [7:0]                 glyph_main, glyph_nb;
  logic [IXW-1:0]             waddr_x, main_x, nb_x;
  logic                       cell_we, glyph_we;
  logic [tog_pkg::GLYPH_AW-1:0] gaddr_main, gaddr_nb;

  logic [tog_pkg::RGB_W-1:0] res_rgb, out_rgb_q, skid_rgb_q;
  logic                      res_drawn, out_drawn_q, skid_drawn_q;
  logic                      out_valid_q, skid_valid_q, take;

  // configuration
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      foreground_q     <= tog_pkg::FOREGROUND_RST;
      shadow_q         <= tog_pkg::SHADOW_RST;
      has_background_q <= 1'b1;
      text_columns_q   <= tog_pkg::COLUMNS_RST;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        tog_pkg::CFG_FOREGROUND: foreground_q     <= cfg_data_i;
        tog_pkg::CFG_SHADOW:     shadow_q         <= cfg_data_i;
        tog_pkg::CFG_HAS_BG:     has_background_q <= cfg_data_i[0];
        tog_pkg::CFG_COLUMNS:    text_columns_q   <= cfg_data_i[tog_pkg::COL_W-1:0];
        default: ;
      endcase
    end
  end

  // the whole pipe moves unless the skid stage holds an item
  assign adv        = !skid_valid_q;
  assign in_stall_o = skid_valid_q;

  tog_index #(
    .CELL_DEPTH(CELL_DEPTH)
  ) u_index (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .adv_i           (adv),
    .valid_i         (in_valid_i),
    .action_i        (action_i),
    .cell_index_i    (cell_index_i),
    .char_code_i     (char_code_i),
    .invert_flag_i   (invert_flag_i),
    .cursor_flag_i   (cursor_flag_i),
    .font_address_i  (font_address_i),
    .font_row_bits_i (font_row_bits_i),
    .pixel_x_i       (pixel_x_i),
    .pixel_y_i       (pixel_y_i),
    .background_rgb_i(background_rgb_i),
    .text_columns_i  (text_columns_q),
    .pix_o           (s2)
  );

  // cell store, one copy per read address
  assign cell_we = adv && s2.valid && s2.cell_we;
  assign waddr_x = IXW'(s2.cell_index);
  assign main_x  = IXW'(s2.main_idx);
  assign nb_x    = IXW'(s2.nb_idx);

  tog_ram #(
    .WIDTH(tog_pkg::CELL_W),
    .DEPTH(CELL_DEPTH)
  ) u_cell_main (
    .clk_i  (clk_i),
    .we_i   (cell_we),
    .waddr_i(waddr_x[CELL_AW-1:0]),
    .wdata_i(s2.cell_word),
    .re_i   (adv),
    .raddr_i(main_x[CELL_AW-1:0]),
    .rdata_o(cell_main)
  );

  tog_ram #(
    .WIDTH(tog_pkg::CELL_W),
    .DEPTH(CELL_DEPTH)
  ) u_cell_nb (
    .clk_i  (clk_i),
    .we_i   (cell_we),
    .waddr_i(waddr_x[CELL_AW-1:0]),
    .wdata_i(s2.cell_word),
    .re_i   (adv),
    .raddr_i(nb_x[CELL_AW-1:0]),
    .rdata_o(cell_nb)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s3_q <= '0;
    end else if (adv) begin
      s3_q <= s2;
    end
  end

  // glyph store, one copy per read address
  assign glyph_we   = adv && s3_q.valid && (s3_q.action == tog_pkg::ACT_GLYPH);
  assign gaddr_main = {cell_main[7:0], s3_q.gy};
  assign gaddr_nb   = {cell_nb[7:0], s3_q.sgy};

  tog_ram #(
    .WIDTH(8),
    .DEPTH(tog_pkg::GLYPH_DEPTH)
  ) u_glyph_main (
    .clk_i  (clk_i),
    .we_i   (glyph_we),
    .waddr_i(s3_q.font_address[tog_pkg::GLYPH_AW-1:0]),
    .wdata_i(s3_q.font_row_bits),
    .re_i   (adv),
    .raddr_i(gaddr_main),
    .rdata_o(glyph_main)
  );

  tog_ram #(
    .WIDTH(8),
    .DEPTH(tog_pkg::GLYPH_DEPTH)
  ) u_glyph_nb (
    .clk_i  (clk_i),
    .we_i   (glyph_we),
    .waddr_i(s3_q.font_address[tog_pkg::GLYPH_AW-1:0]),
    .wdata_i(s3_q.font_row_bits),
    .re_i   (adv),
    .raddr_i(gaddr_nb),
    .rdata_o(glyph_nb)
  );

  // out-of-store cell reads as blank
  always_comb begin
    s4_d.main_ok        = s3_q.main_ok;
    s4_d.nb_ok          = s3_q.nb_ok;
    s4_d.swap           = s3_q.main_ok && (cell_main[9] || cell_main[8]);
    s4_d.gx             = s3_q.gx;
    s4_d.sgx            = s3_q.sgx;
    s4_d.background_rgb = s3_q.background_rgb;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s4_valid_q <= 1'b0;
    end else if (adv) begin
      s4_valid_q <= s3_q.valid && (s3_q.action == tog_pkg::ACT_RENDER);
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s4_q <= s4_d;
    end
  end

  tog_compose u_compose (
    .shade_i         (s4_q),
    .glyph_main_i    (glyph_main),
    .glyph_nb_i      (glyph_nb),
    .foreground_i    (foreground_q),
    .shadow_i        (shadow_q),
    .has_background_i(has_background_q),
    .pixel_rgb_o     (res_rgb),
    .overlay_drawn_o (res_drawn)
  );

  // output register with skid stage
  assign take = out_valid_q && !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (!out_valid_q || take) begin
      if (skid_valid_q) begin
        out_valid_q  <= 1'b1;
        skid_valid_q <= 1'b0;
      end else begin
        out_valid_q <= adv && s4_valid_q;
      end
    end else if (adv && s4_valid_q) begin
      skid_valid_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!out_valid_q || take) begin
      if (skid_valid_q) begin
        out_rgb_q   <= skid_rgb_q;
        out_drawn_q <= skid_drawn_q;
      end else begin
        out_rgb_q   <= res_rgb;
        out_drawn_q <= res_drawn;
      end
    end else if (adv && s4_valid_q) begin
      skid_rgb_q   <= res_rgb;
      skid_drawn_q <= res_drawn;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign pixel_rgb_o     = out_rgb_q;
  assign overlay_drawn_o = out_drawn_q;

  // skid stage only fills behind a waiting result
  a_skid_behind_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> out_valid_q)
    else $error("skid stage full with empty output register");

  a_skid_fill_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(skid_valid_q) |-> $past(out_valid_q && out_stall_i))
    else $error("skid stage filled without a stalled result");

  a_pipe_frozen: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |=> $stable(s4_valid_q) && $stable(s3_q.valid))
    else $error("pipeline moved while skid stage was full");

endmodule

### bench/tb_text_overlay_glyph_shadow_render.sv
// self-checking testbench of the text overlay glyph shadow renderer
`timescale 1ns / 100ps

module tb_text_overlay_glyph_shadow_render;
  import tog_pkg::*;

  localparam int CELL_DEPTH = COLUMNS_DEF * ROWS_DEF;
  localparam logic [1:0] ACT_UNUSED = 2'd3;

  typedef struct packed {
    logic [1:0]  action;
    logic [11:0] cell_index;
    logic [7:0]  char_code;
    logic        invert_flag;
    logic        cursor_flag;
    logic [11:0] font_address;
    logic [7:0]  font_row_bits;
    logic [9:0]  pixel_x;
    logic [8:0]  pixel_y;
    logic [23:0] background_rgb;
  } overlay_item_t;

  typedef struct packed {
    logic [23:0] rgb;
    logic        drawn;
  } pixel_result_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic [23:0] pixel_rgb_o;
  logic        overlay_drawn_o;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [1:0]  cfg_index_i = CFG_FOREGROUND;
  logic [23:0] cfg_data_i = '0;

  overlay_item_t drive_item = '0;

  text_overlay_glyph_shadow_render dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .action_i        (drive_item.action),
    .cell_index_i    (drive_item.cell_index),
    .char_code_i     (drive_item.char_code),
    .invert_flag_i   (drive_item.invert_flag),
    .cursor_flag_i   (drive_item.cursor_flag),
    .font_address_i  (drive_item.font_address),
    .font_row_bits_i (drive_item.font_row_bits),
    .pixel_x_i       (drive_item.pixel_x),
    .pixel_y_i       (drive_item.pixel_y),
    .background_rgb_i(drive_item.background_rgb),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .pixel_rgb_o     (pixel_rgb_o),
    .overlay_drawn_o (overlay_drawn_o),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_o     (cfg_ready_o),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i)
  );

  // predictor state
  logic [23:0] fg_rgb = FOREGROUND_RST;
  logic [23:0] shadow_rgb = SHADOW_RST;
  logic        bg_enable = 1'b1;
  logic [6:0]  cols_cfg = COLUMNS_RST;
  logic [9:0]  cell_mem [CELL_DEPTH];
  logic [7:0]  glyph_mem [GLYPH_DEPTH];
  pixel_result_t pixel_due_q [$];

  // stimulus planning state
  overlay_item_t pending_q [$];
  bit [7:0] plan_code [CELL_DEPTH];
  bit       plan_cell_set [CELL_DEPTH];
  bit       plan_glyph_set [GLYPH_DEPTH];
  int       items_queued = 0;
  int       items_taken = 0;
  int       mismatch_count = 0;

  logic in_fire = 1'b0;
  int   send_gap = 0;
  int   stall_gap = 0;
  bit   send_idle_en = 1'b1;
  bit   recv_idle_en = 1'b1;

  initial begin
    forever #10 clk_i = ~clk_i;
  end

  initial begin
    #10_000_000;
    $display("status: fail");
    $finish;
  end

  function automatic logic fetch_cell(int col, int row, output logic [9:0] word);
    int idx;
    idx = row * cols_cfg + col;
    word = '0;
    if (idx >= CELL_DEPTH) return 1'b0;
    word = cell_mem[idx];
    return 1'b1;
  endfunction

  function automatic logic glyph_bit(logic [9:0] word, int gy, int gx);
    return glyph_mem[word[7:0] * GLYPH_HEIGHT + gy][GLYPH_WIDTH - 1 - gx];
  endfunction

  function automatic logic shadow_cast(int col, int row, int gx, int gy);
    logic [9:0] word;
    if (gx == 0) begin
      if (col == 0) return 1'b0;
      col--;
      gx = GLYPH_WIDTH;
    end
    if (gy == 0) begin
      if (row == 0) return 1'b0;
      row--;
      gy = GLYPH_HEIGHT;
    end
    if (!fetch_cell(col, row, word)) return 1'b0;
    return glyph_bit(word, gy - 1, gx - 1);
  endfunction

  function automatic void absorb_item(overlay_item_t it);
    int col, row, gx, gy;
    logic [9:0] word;
    logic lit;
    pixel_result_t res;
    case (it.action)
      ACT_CELL: begin
        if (it.cell_index < CELL_DEPTH)
          cell_mem[it.cell_index] = {it.cursor_flag, it.invert_flag, it.char_code};
      end
      ACT_GLYPH: glyph_mem[it.font_address] = it.font_row_bits;
      ACT_RENDER: begin
        col = it.pixel_x / GLYPH_WIDTH;
        gx  = it.pixel_x % GLYPH_WIDTH;
        row = it.pixel_y / GLYPH_HEIGHT;
        gy  = it.pixel_y % GLYPH_HEIGHT;
        lit = 1'b0;
        if (fetch_cell(col, row, word)) lit = glyph_bit(word, gy, gx);
        res.drawn = 1'b1;
        if (word[9] || word[8]) res.rgb = lit ? shadow_rgb : fg_rgb;
        else if (lit) res.rgb = fg_rgb;
        else if (!bg_enable || shadow_cast(col, row, gx, gy)) res.rgb = shadow_rgb;
        else begin
          res.rgb = it.background_rgb;
          res.drawn = 1'b0;
        end
        pixel_due_q.push_back(res);
      end
      default: ;
    endcase
  endfunction

  task automatic flag_mismatch(string msg);
    mismatch_count++;
    $display("mismatch at %0t: %s", $realtime, msg);
  endtask

  always @(posedge clk_i) begin : take_items
    pixel_result_t want;
    in_fire <= in_valid_i && !in_stall_o;
    if (in_valid_i && !in_stall_o) begin
      absorb_item(drive_item);
      items_taken <= items_taken + 1;
    end
    if (out_valid_o && !out_stall_i) begin
      if (pixel_due_q.size() == 0) begin
        flag_mismatch("pixel item with none expected");
      end else begin
        want = pixel_due_q.pop_front();
        if (pixel_rgb_o !== want.rgb)
          flag_mismatch($sformatf("pixel_rgb %06h, expected %06h", pixel_rgb_o, want.rgb));
        if (overlay_drawn_o !== want.drawn)
          flag_mismatch($sformatf("overlay_drawn %b, expected %b", overlay_drawn_o, want.drawn));
      end
    end
  end

  always @(negedge clk_i) begin
    if (rst_ni && (!in_valid_i || in_fire)) begin
      if (send_gap != 0) begin
        send_gap <= send_gap - 1;
        in_valid_i <= 1'b0;
      end else if (send_idle_en && in_fire && $urandom_range(0, 5) == 0) begin
        send_gap <= $urandom_range(0, 9);
        in_valid_i <= 1'b0;
      end else if (pending_q.size() != 0) begin
        drive_item <= pending_q.pop_front();
        in_valid_i <= 1'b1;
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  always @(negedge clk_i) begin
    if (stall_gap != 0) begin
      stall_gap <= stall_gap - 1;
      out_stall_i <= 1'b1;
    end else if (recv_idle_en && $urandom_range(0, 7) == 0) begin
      stall_gap <= $urandom_range(0, 9);
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= 1'b0;
    end
  end

  function automatic overlay_item_t fresh_item(logic [1:0] action);
    overlay_item_t it;
    it.action         = action;
    it.cell_index     = 12'($urandom);
    it.char_code      = 8'($urandom);
    it.invert_flag    = 1'($urandom);
    it.cursor_flag    = 1'($urandom);
    it.font_address   = 12'($urandom);
    it.font_row_bits  = 8'($urandom);
    it.pixel_x        = 10'($urandom);
    it.pixel_y        = 9'($urandom);
    it.background_rgb = 24'($urandom);
    return it;
  endfunction

  function automatic void enqueue(overlay_item_t it);
    pending_q.push_back(it);
    items_queued++;
  endfunction

  function automatic void queue_cell(int idx, logic [7:0] code, logic inv, logic cur);
    overlay_item_t it;
    it = fresh_item(ACT_CELL);
    it.cell_index  = 12'(idx);
    it.char_code   = code;
    it.invert_flag = inv;
    it.cursor_flag = cur;
    enqueue(it);
    if (idx < CELL_DEPTH) begin
      plan_cell_set[idx] = 1'b1;
      plan_code[idx] = code;
    end
  endfunction

  function automatic void queue_glyph(int addr, logic [7:0] bits);
    overlay_item_t it;
    it = fresh_item(ACT_GLYPH);
    it.font_address  = 12'(addr);
    it.font_row_bits = bits;
    enqueue(it);
    plan_glyph_set[addr % GLYPH_DEPTH] = 1'b1;
  endfunction

  function automatic logic [7:0] pick_code();
    if ($urandom_range(0, 4) != 0) return 8'(8'h40 + $urandom_range(0, 5));
    return 8'($urandom);
  endfunction

  // write any cell or glyph row a render could read before it goes out
  function automatic void need_cell(int col, int row, int gy);
    int idx, addr;
    idx = row * cols_cfg + col;
    if (idx >= CELL_DEPTH) return;
    if (!plan_cell_set[idx])
      queue_cell(idx, pick_code(), $urandom_range(0, 3) == 0, $urandom_range(0, 5) == 0);
    addr = plan_code[idx] * GLYPH_HEIGHT + gy;
    if (!plan_glyph_set[addr]) queue_glyph(addr, 8'($urandom));
  endfunction

  function automatic void queue_render(int x, int y, logic [23:0] bg);
    overlay_item_t it;
    int col, row, gx, gy;
    bit nb_ok;
    col = x / GLYPH_WIDTH;
    gx  = x % GLYPH_WIDTH;
    row = y / GLYPH_HEIGHT;
    gy  = y % GLYPH_HEIGHT;
    need_cell(col, row, gy);
    nb_ok = 1'b1;
    if (gx == 0) begin
      if (col == 0) nb_ok = 1'b0;
      col--;
    end
    if (gy == 0) begin
      if (row == 0) nb_ok = 1'b0;
      row--;
      gy = GLYPH_HEIGHT;
    end
    if (nb_ok) need_cell(col, row, gy - 1);
    it = fresh_item(ACT_RENDER);
    it.pixel_x = 10'(x);
    it.pixel_y = 9'(y);
    it.background_rgb = bg;
    enqueue(it);
  endfunction

  function automatic void random_item();
    int r;
    logic [23:0] bg;
    r = $urandom_range(0, 99);
    if (r < 60) begin
      bg = 24'($urandom);
      if ($urandom_range(0, 9) == 0) bg = $urandom_range(0, 1) ? 24'hff_ffff : 24'h00_0000;
      if ($urandom_range(0, 9) < 7) queue_render($urandom_range(0, 95), $urandom_range(0, 63), bg);
      else queue_render($urandom_range(0, 1023), $urandom_range(0, 511), bg);
    end else if (r < 78) begin
      queue_cell($urandom_range(0, 6) != 0 ? $urandom_range(0, 255) : $urandom_range(0, 4095),
                 pick_code(), $urandom_range(0, 3) == 0, $urandom_range(0, 5) == 0);
    end else if (r < 95) begin
      if ($urandom_range(0, 9) < 7)
        queue_glyph(pick_code() * GLYPH_HEIGHT + $urandom_range(0, 15), 8'($urandom));
      else queue_glyph($urandom_range(0, 4095), 8'($urandom));
    end else begin
      enqueue(fresh_item(ACT_UNUSED));
    end
  endfunction

  task automatic run_random(int n);
    int target;
    target = items_queued + n;
    while (items_queued < target) random_item();
  endtask

  task automatic wait_drained();
    do @(negedge clk_i); while (items_taken != items_queued || pixel_due_q.size() != 0);
    repeat (12) @(negedge clk_i);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [23:0] data);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      CFG_FOREGROUND: fg_rgb = data;
      CFG_SHADOW:     shadow_rgb = data;
      CFG_HAS_BG:     bg_enable = data[0];
      CFG_COLUMNS:    cols_cfg = data[6:0];
      default: ;
    endcase
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic load_colours(logic [23:0] fg, logic [23:0] sh, logic hb, logic [6:0] cols);
    write_reg(CFG_FOREGROUND, fg);
    write_reg(CFG_SHADOW, sh);
    write_reg(CFG_HAS_BG, {23'd0, hb});
    write_reg(CFG_COLUMNS, {17'd0, cols});
  endtask

  initial begin
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // directed: corners, flags, shadow across cells, ignored writes
    queue_glyph(0, 8'h00);
    queue_glyph(GLYPH_DEPTH - 1, 8'hff);
    queue_glyph(8'h41 * GLYPH_HEIGHT, 8'h81);
    queue_glyph(8'h41 * GLYPH_HEIGHT + 1, 8'h00);
    queue_glyph(8'h41 * GLYPH_HEIGHT + 15, 8'h18);
    queue_cell(0, 8'h41, 1'b0, 1'b0);
    queue_cell(1, 8'hff, 1'b1, 1'b0);
    queue_cell(2, 8'h41, 1'b0, 1'b1);
    queue_cell(80, 8'h00, 1'b1, 1'b1);
    queue_cell(CELL_DEPTH, 8'h12, 1'b1, 1'b1);
    queue_cell(4095, 8'hff, 1'b1, 1'b1);
    enqueue(fresh_item(ACT_UNUSED));
    queue_render(0, 0, 24'h00_0000);
    queue_render(1, 0, 24'hff_ffff);
    queue_render(1, 1, 24'h12_3456);
    queue_render(8, 15, 24'hff_ffff);
    queue_render(23, 15, 24'h00_0000);
    queue_render(8, 16, 24'ha5_5a5a);
    queue_render(1, 16, 24'h5a_a5a5);
    queue_render(639, 479, 24'h00_ff00);
    queue_render(1023, 511, 24'hff_ffff);
    wait_drained();

    load_colours(24'h00_0000, 24'hff_ffff, 1'b0, 7'd1);
    run_random(170);
    wait_drained();

    load_colours(24'($urandom), 24'($urandom), 1'b1, 7'd80);
    send_idle_en = 1'b0;
    run_random(85);
    wait_drained();
    run_random(85);
    wait_drained();

    load_colours(24'($urandom), 24'($urandom), 1'($urandom), 7'($urandom_range(1, 80)));
    send_idle_en = 1'b1;
    recv_idle_en = 1'b0;
    run_random(170);
    wait_drained();

    load_colours(24'($urandom), 24'($urandom), 1'b0, 7'd80);
    recv_idle_en = 1'b1;
    run_random(170);
    wait_drained();

    load_colours(24'hff_ffff, 24'h00_0000, 1'b1, 7'($urandom_range(2, 79)));
    send_idle_en = 1'b0;
    recv_idle_en = 1'b0;
    run_random(170);
    wait_drained();

    if (mismatch_count == 0 && pixel_due_q.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
